// ----- rtl/twa_pkg.sv -----
`timescale 1ns / 1ps
// shared types, codes and constants of the temperature window alarm
// no dependencies; used by every rtl file of the block

package twa_pkg;

    localparam int CMD_W      = 2;
    localparam int PAGE_W     = 2;
    localparam int LIMIT_W    = 8;
    localparam int FAHR_W     = 10;
    localparam int SAMPLE_C_W = 12;
    localparam int SAMPLE_F_W = 14;
    localparam int CMP_W      = 15;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 40;

    localparam logic [CMD_W-1:0] CMD_SET  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INC  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DEC  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_TICK = 2'd3;

    localparam logic [PAGE_W-1:0] PAGE_READ = 2'd0;
    localparam logic [PAGE_W-1:0] PAGE_LOW  = 2'd1;
    localparam logic [PAGE_W-1:0] PAGE_HIGH = 2'd2;

    localparam int LIMIT_MAX_INT  = 125;
    localparam int LIMIT_MIN_INT  = -55;
    localparam int RESET_LOW_INT  = 5;
    localparam int RESET_HIGH_INT = 20;

    localparam logic signed [LIMIT_W-1:0] LIMIT_MAX_C  = LIMIT_W'(LIMIT_MAX_INT);
    localparam logic signed [LIMIT_W-1:0] LIMIT_MIN_C  = LIMIT_W'(LIMIT_MIN_INT);
    localparam logic signed [LIMIT_W-1:0] RESET_LOW_C  = LIMIT_W'(RESET_LOW_INT);
    localparam logic signed [LIMIT_W-1:0] RESET_HIGH_C = LIMIT_W'(RESET_HIGH_INT);
    localparam logic signed [FAHR_W-1:0]  RESET_LOW_F  =
        FAHR_W'((RESET_LOW_INT * 9) / 5 + 32);
    localparam logic signed [FAHR_W-1:0]  RESET_HIGH_F =
        FAHR_W'((RESET_HIGH_INT * 9) / 5 + 32);

    // x/5 as (x*52429)>>18, exact for |x| < 2048
    localparam logic [15:0] FAHR_RECIP = 16'd52429;
    localparam int          FAHR_SHIFT = 18;

    typedef struct packed {
        logic [PAGE_W-1:0]         page;
        logic                      unit_mode;
        logic signed [LIMIT_W-1:0] low_c;
        logic signed [LIMIT_W-1:0] high_c;
        logic signed [FAHR_W-1:0]  low_f;
        logic signed [FAHR_W-1:0]  high_f;
    } t_limits;

    typedef struct packed {
        logic buzzer;
        logic led;
    } t_alarm;

endpackage

// ----- rtl/twa_fahr.sv -----
`timescale 1ns / 1ps
// celsius limit to fahrenheit, (c*9)/5+32 truncated toward zero
// depends on twa_pkg

module twa_fahr (
    input  logic signed [twa_pkg::LIMIT_W-1:0] i_c,
    output logic signed [twa_pkg::FAHR_W-1:0]  o_f
);

    logic signed [11:0] times9;
    logic [10:0]        mag;
    logic [26:0]        prod;
    logic [8:0]         quot;
    logic signed [9:0]  squot;

    assign times9 = $signed({{4{i_c[twa_pkg::LIMIT_W-1]}}, i_c}) * 12'sd9;
    assign mag    = times9[11] ? 11'(-times9) : times9[10:0];
    assign prod   = 27'(mag) * 27'(twa_pkg::FAHR_RECIP);
    assign quot   = prod[26:twa_pkg::FAHR_SHIFT];
    assign squot  = times9[11] ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
    assign o_f    = squot + 10'sd32;

endmodule

// ----- rtl/twa_settings.sv -----
`timescale 1ns / 1ps
// button handling: page, unit mode and the clamped celsius/fahrenheit limits
// depends on twa_pkg and twa_fahr

module twa_settings (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_advance,
    input  logic [twa_pkg::CMD_W-1:0]  i_cmd,
    output twa_pkg::t_limits           o_cur,
    output twa_pkg::t_limits           o_nxt
);

    twa_pkg::t_limits                     r_lim;
    logic [twa_pkg::PAGE_W-1:0]           n_page;
    logic                                 n_unit;
    logic signed [twa_pkg::LIMIT_W-1:0]   n_low_c;
    logic signed [twa_pkg::LIMIT_W-1:0]   n_high_c;
    logic signed [twa_pkg::FAHR_W-1:0]    n_low_f;
    logic signed [twa_pkg::FAHR_W-1:0]    n_high_f;
    logic signed [twa_pkg::LIMIT_W:0]     low_ext;
    logic signed [twa_pkg::LIMIT_W:0]     high_ext;
    logic signed [twa_pkg::LIMIT_W:0]     step_up_low;
    logic signed [twa_pkg::LIMIT_W:0]     step_dn_low;
    logic signed [twa_pkg::LIMIT_W:0]     step_up_high;
    logic signed [twa_pkg::LIMIT_W:0]     step_dn_high;
    logic                                 is_up;

    assign low_ext      = {r_lim.low_c[twa_pkg::LIMIT_W-1], r_lim.low_c};
    assign high_ext     = {r_lim.high_c[twa_pkg::LIMIT_W-1], r_lim.high_c};
    assign step_up_low  = low_ext + 9'sd1;
    assign step_dn_low  = low_ext - 9'sd1;
    assign step_up_high = high_ext + 9'sd1;
    assign step_dn_high = high_ext - 9'sd1;
    assign is_up        = (i_cmd == twa_pkg::CMD_INC);

    always_comb begin
        n_page   = r_lim.page;
        n_unit   = r_lim.unit_mode;
        n_low_c  = r_lim.low_c;
        n_high_c = r_lim.high_c;
        case (i_cmd)
            twa_pkg::CMD_SET: begin
                n_page = (r_lim.page >= twa_pkg::PAGE_HIGH) ? twa_pkg::PAGE_READ
                                                             : r_lim.page + 2'd1;
            end
            twa_pkg::CMD_INC, twa_pkg::CMD_DEC: begin
                case (r_lim.page)
                    twa_pkg::PAGE_READ: begin
                        n_unit = ~r_lim.unit_mode;
                    end
                    twa_pkg::PAGE_LOW: begin
                        if (is_up) begin
                            n_low_c = (step_up_low >= high_ext) ? r_lim.high_c - 8'sd1
                                                                : step_up_low[7:0];
                        end else begin
                            n_low_c = (step_dn_low <= 9'(twa_pkg::LIMIT_MIN_C))
                                      ? twa_pkg::LIMIT_MIN_C : step_dn_low[7:0];
                        end
                    end
                    twa_pkg::PAGE_HIGH: begin
                        if (is_up) begin
                            n_high_c = (step_up_high >= 9'(twa_pkg::LIMIT_MAX_C))
                                       ? twa_pkg::LIMIT_MAX_C : step_up_high[7:0];
                        end else begin
                            n_high_c = (step_dn_high <= low_ext) ? r_lim.low_c + 8'sd1
                                                                 : step_dn_high[7:0];
                        end
                    end
                    default: begin
                        n_low_c = r_lim.low_c;
                    end
                endcase
            end
            default: begin
                n_page = r_lim.page;
            end
        endcase
    end

    twa_fahr u_fahr_low (
        .i_c (n_low_c),
        .o_f (n_low_f)
    );

    twa_fahr u_fahr_high (
        .i_c (n_high_c),
        .o_f (n_high_f)
    );

    always_comb begin
        o_nxt.page      = n_page;
        o_nxt.unit_mode = n_unit;
        o_nxt.low_c     = n_low_c;
        o_nxt.high_c    = n_high_c;
        o_nxt.low_f     = n_low_f;
        o_nxt.high_f    = n_high_f;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim.page      <= twa_pkg::PAGE_READ;
            r_lim.unit_mode <= 1'b0;
            r_lim.low_c     <= twa_pkg::RESET_LOW_C;
            r_lim.high_c    <= twa_pkg::RESET_HIGH_C;
            r_lim.low_f     <= twa_pkg::RESET_LOW_F;
            r_lim.high_f    <= twa_pkg::RESET_HIGH_F;
        end else if (i_advance) begin
            r_lim <= o_nxt;
        end
    end

    assign o_cur = r_lim;

endmodule

// ----- rtl/twa_alarm.sv -----
`timescale 1ns / 1ps
// window comparator on tick: buzzer and toggling led while at or outside limits
// depends on twa_pkg

module twa_alarm (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_advance,
    input  logic [twa_pkg::CMD_W-1:0]             i_cmd,
    input  logic signed [twa_pkg::SAMPLE_C_W-1:0] i_sample_c,
    input  logic signed [twa_pkg::SAMPLE_F_W-1:0] i_sample_f,
    input  twa_pkg::t_limits                      i_lim,
    output twa_pkg::t_alarm                       o_nxt
);

    twa_pkg::t_alarm                    r_alarm;
    logic signed [twa_pkg::CMP_W-1:0]   smp;
    logic signed [twa_pkg::CMP_W-1:0]   lo;
    logic signed [twa_pkg::CMP_W-1:0]   hi;
    logic                               outside;

    always_comb begin
        if (i_lim.unit_mode) begin
            smp = $signed({i_sample_f[13], i_sample_f});
            lo  = $signed({i_lim.low_f[9], i_lim.low_f, 4'b0000});
            hi  = $signed({i_lim.high_f[9], i_lim.high_f, 4'b0000});
        end else begin
            smp = $signed({{3{i_sample_c[11]}}, i_sample_c});
            lo  = $signed({{3{i_lim.low_c[7]}}, i_lim.low_c, 4'b0000});
            hi  = $signed({{3{i_lim.high_c[7]}}, i_lim.high_c, 4'b0000});
        end
    end

    assign outside = (smp <= lo) || (smp >= hi);

    always_comb begin
        o_nxt = r_alarm;
        if (i_cmd == twa_pkg::CMD_TICK) begin
            o_nxt.buzzer = outside;
            o_nxt.led    = outside & ~r_alarm.led;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alarm <= '0;
        end else if (i_advance) begin
            r_alarm <= o_nxt;
        end
    end

endmodule

// ----- rtl/temperature_window_alarm_core.sv -----
`timescale 1ns / 1ps
// temperature window alarm, top level: input stage, result stage, handshake
// depends on twa_pkg, twa_settings and twa_alarm
//
// usage:
//   slave channel takes one event per beat: tuser is the command (set,
//   increment, decrement, tick), tdata carries the celsius and fahrenheit
//   samples that a tick compares against the limits
//   master channel returns exactly one beat per event: buzzer, led, page,
//   unit mode and the four limits as they stand after that event
//   an accepted input beat waits in the input register, and its result goes
//   into the result register that drives o_m_axis_tvalid;
//   throughput is one event per cycle unless the receiver stalls, set by the
//   single compute stage between the input register and the result register
//   a stalled receiver holds the result register; one more event waits in
//   the input register and tready drops only when both stages are full
//   reset clears both stages, returns the page to reading, the unit to
//   celsius, the limits to 5 and 20 degrees and switches buzzer and led off

module temperature_window_alarm_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // sample_c[11:0], sample_f[25:12], zero fill
    input  logic [twa_pkg::IN_DATA_W-1:0]     i_s_axis_tdata,
    // cmd[1:0]
    input  logic [twa_pkg::CMD_W-1:0]         i_s_axis_tuser,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // buzzer[0], led[1], page[3:2], unit_mode[4], low_c[12:5], high_c[20:13],
    // low_f[29:21], high_f[39:30]
    output logic [twa_pkg::OUT_DATA_W-1:0]    o_m_axis_tdata
);

    logic                                  r_in_valid;
    logic [twa_pkg::CMD_W-1:0]             r_in_cmd;
    logic signed [twa_pkg::SAMPLE_C_W-1:0] r_in_sample_c;
    logic signed [twa_pkg::SAMPLE_F_W-1:0] r_in_sample_f;
    logic                                  r_out_valid;
    logic [twa_pkg::OUT_DATA_W-1:0]        r_out_data;
    logic [twa_pkg::OUT_DATA_W-1:0]        n_out_data;
    logic                                  advance;
    logic                                  in_beat;
    twa_pkg::t_limits                      cur_lim;
    twa_pkg::t_limits                      nxt_lim;
    twa_pkg::t_alarm                       nxt_alarm;

    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;
    assign in_beat         = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_beat) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_in_cmd      <= i_s_axis_tuser;
            r_in_sample_c <= i_s_axis_tdata[11:0];
            r_in_sample_f <= i_s_axis_tdata[25:12];
        end
    end

    twa_settings u_settings (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_cmd     (r_in_cmd),
        .o_cur     (cur_lim),
        .o_nxt     (nxt_lim)
    );

    twa_alarm u_alarm (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_advance  (advance),
        .i_cmd      (r_in_cmd),
        .i_sample_c (r_in_sample_c),
        .i_sample_f (r_in_sample_f),
        .i_lim      (cur_lim),
        .o_nxt      (nxt_alarm)
    );

    assign n_out_data = {nxt_lim.high_f,
                         nxt_lim.low_f[8:0],
                         nxt_lim.high_c,
                         nxt_lim.low_c,
                         nxt_lim.unit_mode,
                         nxt_lim.page,
                         nxt_alarm.led,
                         nxt_alarm.buzzer};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

`ifndef SYNTHESIS
    a_window_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cur_lim.low_c < cur_lim.high_c)
        else $error("low limit not below high limit");

    a_limits_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cur_lim.low_c >= twa_pkg::LIMIT_MIN_C) && (cur_lim.high_c <= twa_pkg::LIMIT_MAX_C))
        else $error("limit outside clamp range");

    a_led_needs_buzzer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[1] |-> o_m_axis_tdata[0])
        else $error("led on without buzzer");

    a_page_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[3:2] != 2'd3))
        else $error("unreachable page shown");

    a_one_result_per_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> o_m_axis_tvalid)
        else $error("event produced no result");
`endif

endmodule
